@@ sv/ctcl_pkg.sv @@
// Shared types, constants and helpers for the color target column locator.
// No dependencies; every other file of the block imports this package.
package ctcl_pkg;

   localparam int MAX_MATCHES = 524288;
   localparam int MAX_WIDTH   = 1024;

   localparam int PIX_W  = 8;
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ADDR_W = $clog2(MAX_MATCHES);
   localparam int CNT_W  = ADDR_W + 1;
   localparam int XC_W   = 11;
   localparam int FW_W   = 11;
   localparam int CLS_W  = 2;
   localparam int IDX_W  = 1;

   // pixel classes, also the target color codes
   localparam logic [CLS_W-1:0] CLASS_BLUE  = 2'd0;
   localparam logic [CLS_W-1:0] CLASS_GREEN = 2'd1;
   localparam logic [CLS_W-1:0] CLASS_RED   = 2'd2;
   localparam logic [CLS_W-1:0] CLASS_NONE  = 2'd3;

   // register indexes
   localparam logic [IDX_W-1:0] REG_TARGET_COLOR = 1'd0;
   localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 1'd1;

   localparam logic [CLS_W-1:0] TARGET_COLOR_RESET = CLASS_RED;
   localparam logic [FW_W-1:0]  FRAME_WIDTH_RESET  = 11'd800;

   localparam logic [XC_W-1:0]  X_NONE = '1;   // -1

   typedef logic [CLS_W-1:0] class_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [COL_W-1:0]  wr_col;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } store_req_type;

endpackage

@@ sv/ctcl_classify.sv @@
// Dominant-channel classifier: strict maximum, red first, then green, blue.
// Depends on ctcl_pkg.
module ctcl_classify (
   input  logic [ctcl_pkg::PIX_W-1:0] blue,
   input  logic [ctcl_pkg::PIX_W-1:0] green,
   input  logic [ctcl_pkg::PIX_W-1:0] red,
   output ctcl_pkg::class_type        pixel_class
);
   import ctcl_pkg::*;

   always_comb begin
      if (red != '0 && red > green && red > blue) begin
         pixel_class = CLASS_RED;
      end else if (green != '0 && green > blue && green > red) begin
         pixel_class = CLASS_GREEN;
      end else if (blue != '0 && blue > green && blue > red) begin
         pixel_class = CLASS_BLUE;
      end else begin
         pixel_class = CLASS_NONE;
      end
   end

endmodule

@@ sv/ctcl_match_store.sv @@
// Match column store: one write and one registered read per cycle.
// Depends on ctcl_pkg; a read of the address written in the same cycle forwards.
module ctcl_match_store (
   input  logic                       clock,
   input  ctcl_pkg::store_req_type    store_req,
   output logic [ctcl_pkg::COL_W-1:0] rd_col
);
   import ctcl_pkg::*;

   logic [COL_W-1:0] mem [MAX_MATCHES];
   logic [COL_W-1:0] rd_col_ff;

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         mem[store_req.wr_addr] <= store_req.wr_col;
      end
   end

   // hold the read data between reads
   always_ff @(posedge clock) begin
      if (store_req.rd_en) begin
         if (store_req.wr_en && store_req.wr_addr == store_req.rd_addr) begin
            rd_col_ff <= store_req.wr_col;
         end else begin
            rd_col_ff <= mem[store_req.rd_addr];
         end
      end
   end

   assign rd_col = rd_col_ff;

endmodule

@@ sv/color_target_column_locator.sv @@
// Top level of the color target column locator: pixel stream in, one result per frame.
// Depends on ctcl_pkg, ctcl_classify and ctcl_match_store.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------------
//  req     | in        | req_tvalid/tready   | tdata: blue, green, red; tlast: frame_end
//  rsp     | out       | rsp_tvalid/tready   | tdata: x_coord, match_count
//  csr     | in        | csr_valid/csr_ready | csr_index, csr_data (always ready)
//
// One pixel request per cycle, sustained while rsp is not stalled. A request passes an
// input register (s1), where it is classified, its column stored and the middle match
// read; on the frame's last pixel the store read lands in s2 and the result then moves
// on to the output register. The store port takes one write and one read per cycle.
// Reset clears control state; the store needs no clearing.
// A stalled result holds in rsp, then s2, then s1 before req_tready drops.
module color_target_column_locator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] blue, [15:8] green, [23:16] red
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [10:0] x_coord (signed), [30:11] match_count
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [ctcl_pkg::IDX_W-1:0] csr_index,
   input  logic [ctcl_pkg::FW_W-1:0]  csr_data
);
   import ctcl_pkg::*;

   // configuration
   class_type        target_color_ff;
   logic [FW_W-1:0]  frame_width_ff;

   // s1: input register
   logic             s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0] s1_blue_ff, s1_green_ff, s1_red_ff;
   logic             s1_last_ff;

   // frame state
   logic [COL_W-1:0] column_ff, column_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // s2: result waiting for the store read
   logic             s2_valid_ff, s2_valid_in;
   logic [CNT_W-1:0] s2_count_ff;
   logic             s2_any_ff;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [XC_W-1:0]  rsp_x_ff;
   logic [CNT_W-1:0] rsp_count_ff;

   logic             s1_fire, s1_go, s2_go;
   class_type        pixel_class;
   logic             store_hit;
   logic [CNT_W-1:0] count_next;
   logic [COL_W:0]   column_inc;
   store_req_type    store_req;
   logic [COL_W-1:0] rd_col;
   logic [COL_W-1:0] mid_col;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_color_ff <= TARGET_COLOR_RESET;
         frame_width_ff  <= FRAME_WIDTH_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_TARGET_COLOR: target_color_ff <= csr_data[CLS_W-1:0];
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // pipeline flow: each stage moves when the one after it has room
   assign s2_go      = !rsp_valid_ff || rsp_tready;
   assign s1_go      = !s2_valid_ff || s2_go;
   assign s1_fire    = s1_valid_ff && s1_go;
   assign req_tready = !s1_valid_ff || s1_go;

   assign s1_valid_in = (req_tvalid && req_tready) ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_blue_ff  <= req_tdata[7:0];
         s1_green_ff <= req_tdata[15:8];
         s1_red_ff   <= req_tdata[23:16];
         s1_last_ff  <= req_tlast;
      end
   end

   ctcl_classify u_classify (
      .blue        (s1_blue_ff),
      .green       (s1_green_ff),
      .red         (s1_red_ff),
      .pixel_class (pixel_class)
   );

   // store a match unless the store is already full (top count bit set)
   assign store_hit  = (pixel_class == target_color_ff) && !count_ff[CNT_W-1];
   assign count_next = count_ff + CNT_W'(store_hit);
   assign column_inc = {1'b0, column_ff} + 1'b1;

   always_comb begin
      store_req.wr_en   = s1_fire && store_hit;
      store_req.wr_addr = count_ff[ADDR_W-1:0];
      store_req.wr_col  = column_ff;
      store_req.rd_en   = s1_fire && s1_last_ff;
      store_req.rd_addr = count_next[CNT_W-1:1];
   end

   // advance the column, wrapping at the row width; clear all at frame end
   always_comb begin
      column_in = column_ff;
      count_in  = count_ff;
      if (s1_fire) begin
         if (s1_last_ff) begin
            column_in = '0;
            count_in  = '0;
         end else begin
            count_in = count_next;
            if (FW_W'(column_inc) >= frame_width_ff || column_inc[COL_W]) begin
               column_in = '0;
            end else begin
               column_in = column_inc[COL_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         count_ff  <= '0;
      end else begin
         column_ff <= column_in;
         count_ff  <= count_in;
      end
   end

   ctcl_match_store u_store (
      .clock     (clock),
      .store_req (store_req),
      .rd_col    (rd_col)
   );

   // s2 holds only frame results
   assign s2_valid_in = s1_fire ? s1_last_ff : (s2_go ? 1'b0 : s2_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_req.rd_en) begin
         s2_count_ff <= count_next;
         s2_any_ff   <= count_next != '0;
      end
   end

   // no match, or a middle match at column zero, reports -1
   assign mid_col      = s2_any_ff ? rd_col : '0;
   assign rsp_valid_in = s2_go ? s2_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_go && s2_valid_ff) begin
         rsp_x_ff     <= (mid_col == '0) ? X_NONE : XC_W'(mid_col);
         rsp_count_ff <= s2_count_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_count_ff, rsp_x_ff};

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_MATCHES))
      else $error("match count beyond store depth");

   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_last_ff |=> count_ff == '0 && column_ff == '0)
      else $error("frame state not cleared after last pixel");

   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !s2_go |=> s2_valid_ff && $stable(s2_count_ff))
      else $error("stalled frame result lost in s2");

   a_x_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_x_ff != '0)
      else $error("column zero reported instead of -1");
`endif

endmodule
